/* hw/rtl/frl_pkg.sv */
// ----------------------------------------------------------------------------
// frl_pkg: shared types and constants of the firmware record loader
// Item structs, parser phases, result codes and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package frl_pkg;

  // register map, index = paddr[3:2]
  localparam int unsigned RegAddrW = 4;
  localparam logic [1:0] REG_HEADER_SKIP = 2'd0;
  localparam logic [1:0] REG_RUN_ADDRESS = 2'd1;
  localparam logic [1:0] REG_MIN_LENGTH  = 2'd2;

  localparam logic [7:0]  HEADER_SKIP_RESET = 8'd8;
  localparam logic [15:0] RUN_ADDRESS_RESET = 16'he600;
  localparam logic [7:0]  MIN_LENGTH_RESET  = 8'd13;

  localparam logic [14:0] LEN_MASK = 15'h7fff;
  localparam logic [7:0]  COUNT_MAX = 8'hff;

  // result queue
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QCntW = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_SIZE_HI = 3'd1,
    PH_SIZE_LO = 3'd2,
    PH_ADDR_HI = 3'd3,
    PH_ADDR_LO = 3'd4,
    PH_DATA    = 3'd5,
    PH_WAIT    = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_FINISH = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK_STARTED   = 2'd0,
    ST_START_NEEDED = 2'd1,
    ST_TRUNCATED    = 2'd2,
    ST_TOO_SHORT    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       image_last;
  } image_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] write_address;
    logic [7:0]  write_byte;
    logic [1:0]  finish_status;
    logic        last_of_run;
  } result_item_t;

endpackage

`default_nettype wire

/* hw/rtl/firmware_record_loader_core.sv */
// ----------------------------------------------------------------------------
// firmware_record_loader_core: firmware image record parser
// Skips the image header, parses size/address records and issues one memory
// write per data byte, then one finish item with the image status.
// ----------------------------------------------------------------------------
`default_nettype none

// The core takes one image byte per clock while image_stall is low. Each
// byte is parsed in the cycle it is accepted and gives zero, one or two
// result items (a write, a finish, or the final data write followed by its
// finish); these enter a four-entry result queue and appear at the output
// from the next cycle on. The queue drains one item per cycle unless
// result_stall is high; image_stall rises when more than two items are
// queued. Without output stalls, data bytes run at one byte per cycle.
// Register writes via the APB port are meant for idle periods between images.
module firmware_record_loader_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   image_valid,
  output logic                        image_stall,
  input  wire frl_pkg::image_item_t   image,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output frl_pkg::result_item_t       result,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [frl_pkg::RegAddrW-1:0] paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import frl_pkg::*;

  // configuration
  logic [7:0]  header_skip;
  logic [15:0] run_address;
  logic [7:0]  min_image_length;
  logic        cfg_we;

  // parser state
  phase_t      phase, phase_next, phase_proc, ph_eff;
  logic [7:0]  header_count, header_count_next;
  logic [7:0]  bytes_seen, bytes_seen_next;
  logic [15:0] size_field, size_field_next;
  logic [15:0] record_address, record_address_next;
  logic [14:0] bytes_left, bytes_left_next;
  logic        already_started, already_started_next, started_proc;
  logic        finish_pending, finish_pending_next;
  logic        consumed, end_done, reach;

  // per-item results
  logic         wr_en, fin_en;
  status_t      fin_status;
  result_item_t res_a, res_b;
  logic [1:0]   res_n;

  // result queue, head at entry 0
  result_item_t q [QueueDepth];
  result_item_t q_next [QueueDepth];
  logic [QCntW-1:0] count, base;

  logic accept, pop;
  logic [7:0] b;

  assign accept = image_valid && !image_stall;
  assign pop    = result_valid && !result_stall;
  assign b      = image.image_byte;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_skip      <= HEADER_SKIP_RESET;
      run_address      <= RUN_ADDRESS_RESET;
      min_image_length <= MIN_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_HEADER_SKIP: header_skip      <= pwdata[7:0];
        REG_RUN_ADDRESS: run_address      <= pwdata[15:0];
        REG_MIN_LENGTH:  min_image_length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HEADER_SKIP: prdata = {24'd0, header_skip};
      REG_RUN_ADDRESS: prdata = {16'd0, run_address};
      REG_MIN_LENGTH:  prdata = {24'd0, min_image_length};
      default:         prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // parser next state
  // --------------------------------------------------------------------------
  always_comb begin
    header_count_next   = header_count;
    size_field_next     = size_field;
    record_address_next = record_address;
    bytes_left_next     = bytes_left;
    started_proc        = already_started;
    finish_pending_next = finish_pending;
    end_done            = 1'b0;
    consumed            = 1'b0;

    bytes_seen_next = bytes_seen + 8'(bytes_seen != COUNT_MAX);
    reach = bytes_seen_next >= min_image_length;

    ph_eff = phase;
    if (phase == PH_HEADER) begin
      if (header_count < header_skip) begin
        header_count_next = header_count + 8'd1;
        consumed = 1'b1;
      end else begin
        ph_eff = PH_SIZE_HI;
      end
    end

    phase_proc = ph_eff;
    if (!consumed) begin
      unique case (ph_eff)
        PH_SIZE_HI: begin
          size_field_next = {b, 8'h00};
          phase_proc = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          size_field_next = {size_field[15:8], b};
          phase_proc = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          record_address_next = {b, 8'h00};
          phase_proc = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          record_address_next = {record_address[15:8], b};
          bytes_left_next = size_field[14:0] & LEN_MASK;
          if (size_field[14:0] != 15'd0) begin
            phase_proc = PH_DATA;
          end else if (size_field[15]) begin
            end_done = 1'b1;
          end else begin
            phase_proc = PH_SIZE_HI;
          end
        end
        PH_DATA: begin
          // single zero byte to the run control means the cpu is running
          if (size_field[15] && size_field[14:0] == 15'd1 &&
              record_address == run_address && b == 8'd0) begin
            started_proc = 1'b1;
          end
          record_address_next = record_address + 16'd1;
          bytes_left_next = bytes_left - 15'd1;
          if (bytes_left == 15'd1) begin
            if (size_field[15]) begin
              end_done = 1'b1;
            end else begin
              phase_proc = PH_SIZE_HI;
            end
          end
        end
        PH_WAIT: begin
          if (reach) begin
            phase_proc = PH_DONE;
            finish_pending_next = 1'b0;
          end
        end
        default: ;
      endcase
    end

    if (end_done) begin
      if (reach || image.image_last) begin
        phase_proc = PH_DONE;
        finish_pending_next = 1'b0;
      end else begin
        phase_proc = PH_WAIT;
        finish_pending_next = 1'b1;
      end
    end

    phase_next           = phase_proc;
    already_started_next = started_proc;
    // image end clears everything for the next image
    if (image.image_last) begin
      phase_next           = PH_HEADER;
      header_count_next    = 8'd0;
      bytes_seen_next      = 8'd0;
      size_field_next      = 16'd0;
      record_address_next  = 16'd0;
      bytes_left_next      = 15'd0;
      already_started_next = 1'b0;
      finish_pending_next  = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // parser outputs
  // --------------------------------------------------------------------------
  always_comb begin
    logic fin_now;
    wr_en   = !consumed && ph_eff == PH_DATA;
    fin_now = (end_done && (reach || image.image_last)) ||
              (!consumed && ph_eff == PH_WAIT && reach);

    if (fin_now) begin
      fin_status = !reach ? ST_TOO_SHORT :
                   (started_proc ? ST_OK_STARTED : ST_START_NEEDED);
    end else if (!reach) begin
      fin_status = ST_TOO_SHORT;
    end else if (phase_proc == PH_DATA) begin
      fin_status = ST_TRUNCATED;
    end else if (phase_proc == PH_WAIT) begin
      fin_status = started_proc ? ST_OK_STARTED : ST_START_NEEDED;
    end else begin
      fin_status = ST_START_NEEDED;
    end
    fin_en = fin_now || (image.image_last && phase_proc != PH_DONE);

    res_b.kind          = KIND_FINISH;
    res_b.write_address = 16'd0;
    res_b.write_byte    = 8'd0;
    res_b.finish_status = fin_status;
    res_b.last_of_run   = 1'b1;

    if (wr_en) begin
      res_a.kind          = KIND_WRITE;
      res_a.write_address = record_address;
      res_a.write_byte    = b;
      res_a.finish_status = ST_OK_STARTED;
      res_a.last_of_run   = !fin_en;
    end else begin
      res_a = res_b;
    end

    res_n = accept ? (2'(wr_en) + 2'(fin_en)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= 8'd0;
      bytes_seen      <= 8'd0;
      size_field      <= 16'd0;
      record_address  <= 16'd0;
      bytes_left      <= 15'd0;
      already_started <= 1'b0;
      finish_pending  <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      bytes_seen      <= bytes_seen_next;
      size_field      <= size_field_next;
      record_address  <= record_address_next;
      bytes_left      <= bytes_left_next;
      already_started <= already_started_next;
      finish_pending  <= finish_pending_next;
    end
  end

  // --------------------------------------------------------------------------
  // result queue: shifts toward the head on a pop, appends up to two items
  // --------------------------------------------------------------------------
  assign result_valid = count != '0;
  assign result       = q[0];
  // room for two more items
  assign image_stall  = count > QCntW'(QueueDepth - 2);

  always_comb begin
    base = count - QCntW'(pop);
    for (int i = 0; i < QueueDepth; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < QueueDepth - 1; i++) begin
        q_next[i] = q[i + 1];
      end
    end
    for (int i = 0; i < QueueDepth; i++) begin
      if (res_n != 2'd0 && base == QCntW'(i)) begin
        q_next[i] = res_a;
      end
      if (res_n == 2'd2 && base + QCntW'(1) == QCntW'(i)) begin
        q_next[i] = res_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QueueDepth; i++) begin
      q[i] <= q_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= base + QCntW'(res_n);
    end
  end

endmodule

`default_nettype wire
